// ===== src/ntvc_pkg.sv =====
// Shared types and constants for the nearest template vowel classifier.
// No dependencies; every other file imports this package.
`default_nettype none

package ntvc_pkg;

  localparam int NUM_TEMPLATES_DEF = 7;
  localparam int NUM_COEFFS_DEF    = 16;

  localparam int COEFF_W = 16;
  localparam int SQ_W    = 32;
  localparam int SUM_W   = 48;
  localparam int ADDR_W  = 5;   // enough for the largest coefficient count of 32
  localparam int IDX_W   = 4;   // enough for the largest template count of 16
  localparam int CODE_W  = 3;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;

  localparam logic signed [COEFF_W-1:0] RANGE_POS = 16'sd25600;
  localparam logic signed [COEFF_W-1:0] RANGE_NEG = -16'sd25600;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_QUIET = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Feature coefficient travelling down the row of cells.
  typedef struct packed {
    logic                      valid;
    logic                      acc_en;
    logic                      last;
    logic [ADDR_W-1:0]         addr;
    logic signed [COEFF_W-1:0] value;
  } tok_t;

  // Running minimum travelling down the row after the last coefficient.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] sum;
  } cmp_t;

endpackage

`default_nettype wire

// ===== src/nearest_template_vowel_classifier.sv =====
// Top level: command interface, energy floor register and the row of
// template cells. Uses ntvc_pkg and ntvc_cell.
`default_nettype none

// A request is taken when start is high and busy is low. A load request
// writes one template coefficient and leaves busy low. A feature request
// flows down the row of NUM_TEMPLATES cells, one cell per cycle, and keeps
// busy high while it passes through the row. A feature request with last
// set also sends the running minimum down the same row after the final
// accumulation; its result appears with out_valid for one cycle, and busy
// stays high until the cycle before it. The receiver cannot stall, so
// out_valid must be sampled in the cycle it is shown. The energy floor is
// written and read over the APB port at byte address 0.

module nearest_template_vowel_classifier import ntvc_pkg::*; #(
  parameter int NUM_TEMPLATES = NUM_TEMPLATES_DEF,
  parameter int NUM_COEFFS    = NUM_COEFFS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_mode,
  input  wire logic [2:0]                in_template_index,
  input  wire logic [3:0]                in_coeff_index,
  input  wire logic signed [COEFF_W-1:0] in_value,
  input  wire logic [31:0]               in_frame_energy,
  input  wire logic                      in_last,
  output logic                           out_valid,
  output logic [CODE_W-1:0]              out_class_code,
  output logic [STAT_W-1:0]              out_status,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic              accept, feat, load, cidx_ok, out_of_range;
  logic [31:0]       floor_r;
  tok_t              tok_head_r;
  logic [2:0]        last_dly_r;
  cmp_t              cmp_head;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              quiet_r, range_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] code_r;
  status_t           status_r;
  logic [IDX_W:0]    best_plus1;

  tok_t tok_c [NUM_TEMPLATES];
  cmp_t cmp_c [NUM_TEMPLATES];

  assign accept       = start && !busy;
  assign feat         = accept && in_mode;
  assign load         = accept && !in_mode;
  assign cidx_ok      = int'(in_coeff_index) < NUM_COEFFS;
  assign out_of_range = (in_value >= RANGE_POS) || (in_value <= RANGE_NEG);

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      floor_r <= pwdata;
    end
  end

  // Busy counter covers the pass through the row and, for the last
  // coefficient, the minimum search.
  always_comb begin
    cnt_nxt = cnt_r;
    if (feat) begin
      cnt_nxt = in_last ? CNT_W'(NUM_TEMPLATES + 4) : CNT_W'(NUM_TEMPLATES + 2);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign busy = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r            <= '0;
      tok_head_r.valid <= 1'b0;
      last_dly_r       <= '0;
      range_r          <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      cnt_r             <= cnt_nxt;
      tok_head_r.valid  <= feat;
      tok_head_r.acc_en <= cidx_ok;
      tok_head_r.last   <= in_last;
      tok_head_r.addr   <= {1'b0, in_coeff_index};
      tok_head_r.value  <= in_value;
      last_dly_r        <= {last_dly_r[1:0], tok_head_r.valid && tok_head_r.last};
      if (cmp_c[NUM_TEMPLATES-1].valid) begin
        range_r <= 1'b0;
      end else if (feat && cidx_ok && out_of_range) begin
        range_r <= 1'b1;
      end
      out_valid_r <= cmp_c[NUM_TEMPLATES-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feat && in_last) begin
      quiet_r <= !(in_frame_energy > floor_r);
    end
  end

  assign best_plus1 = {1'b0, cmp_c[NUM_TEMPLATES-1].idx} + 1'b1;

  always_ff @(posedge clk) begin
    if (quiet_r) begin
      code_r   <= '0;
      status_r <= ST_QUIET;
    end else if (range_r) begin
      code_r   <= '0;
      status_r <= ST_RANGE;
    end else begin
      code_r   <= best_plus1[CODE_W-1:0];
      status_r <= ST_OK;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_class_code = code_r;
  assign out_status     = status_r;

  always_comb begin
    cmp_head.valid = last_dly_r[2];
    cmp_head.idx   = '0;
    cmp_head.sum   = '0;
  end

  for (genvar i = 0; i < NUM_TEMPLATES; i++) begin : g_cell
    logic wr_en;
    tok_t tok_in;
    cmp_t cmp_in;

    assign wr_en = load && cidx_ok && (int'(in_template_index) == i);

    if (i == 0) begin : g_first
      assign tok_in = tok_head_r;
      assign cmp_in = cmp_head;
    end else begin : g_next
      assign tok_in = tok_c[i-1];
      assign cmp_in = cmp_c[i-1];
    end

    ntvc_cell #(
      .NUM_COEFFS (NUM_COEFFS),
      .IDX        (IDX_W'(i))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en),
      .wr_addr ({1'b0, in_coeff_index}),
      .wr_data (in_value),
      .tok_i   (tok_in),
      .tok_o   (tok_c[i]),
      .cmp_i   (cmp_in),
      .cmp_o   (cmp_c[i])
    );
  end

  // A coefficient still in the row means a request is still in progress.
  a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok_c[NUM_TEMPLATES-1].valid |-> busy)
    else $error("coefficient in flight while idle");

  // A frame end keeps the block busy until its result is out.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode && in_last) |=> busy)
    else $error("frame end accepted without going busy");

  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_class_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && NUM_TEMPLATES < 8) |-> out_class_code != '0)
    else $error("classified frame without a template");

endmodule

`default_nettype wire

// ===== src/ntvc_cell.sv =====
// One template cell: its coefficient row, a squared-difference MAC with a
// saturating accumulator, and one step of the minimum search. Uses ntvc_pkg.
`default_nettype none

module ntvc_cell import ntvc_pkg::*; #(
  parameter int               NUM_COEFFS = NUM_COEFFS_DEF,
  parameter logic [IDX_W-1:0] IDX        = '0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      wr_en,
  input  wire logic [ADDR_W-1:0]         wr_addr,
  input  wire logic signed [COEFF_W-1:0] wr_data,
  input  wire tok_t                      tok_i,
  output tok_t                           tok_o,
  input  wire cmp_t                      cmp_i,
  output cmp_t                           cmp_o
);

  localparam int AW = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;

  logic signed [COEFF_W-1:0] mem_r [2**AW];
  logic signed [COEFF_W-1:0] rd_r;
  tok_t                      tok_r;
  logic                      sq_vld_r;
  logic [SQ_W-1:0]           sq_r;
  logic [SUM_W-1:0]          acc_r, acc_nxt;
  cmp_t                      cmp_r, cmp_nxt;
  logic signed [COEFF_W:0]   diff;
  logic [COEFF_W-1:0]        mag;
  logic [SUM_W:0]            sum_ext;
  logic                      take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr[AW-1:0]] <= wr_data;
    end
    rd_r <= mem_r[tok_i.addr[AW-1:0]];
  end

  // The magnitude of a 17-bit difference never exceeds 65535.
  assign diff = {rd_r[COEFF_W-1], rd_r} - {tok_r.value[COEFF_W-1], tok_r.value};
  assign mag  = diff[COEFF_W] ? COEFF_W'(-diff) : COEFF_W'(diff);

  assign sum_ext = {1'b0, acc_r} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_r};

  always_comb begin
    acc_nxt = acc_r;
    if (sq_vld_r) begin
      acc_nxt = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end
    // The minimum search reads the final sum and starts the next frame at zero.
    if (cmp_i.valid) begin
      acc_nxt = '0;
    end
  end

  // The first cell always takes the lead, so ties go to the lowest index.
  assign take = (IDX == '0) || (acc_r < cmp_i.sum);

  always_comb begin
    cmp_nxt.valid = cmp_i.valid;
    cmp_nxt.idx   = take ? IDX : cmp_i.idx;
    cmp_nxt.sum   = take ? acc_r : cmp_i.sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      sq_vld_r    <= 1'b0;
      acc_r       <= '0;
      cmp_r.valid <= 1'b0;
    end else begin
      tok_r    <= tok_i;
      sq_vld_r <= tok_r.valid && tok_r.acc_en;
      sq_r     <= {{(SQ_W - COEFF_W){1'b0}}, mag} * {{(SQ_W - COEFF_W){1'b0}}, mag};
      acc_r    <= acc_nxt;
      cmp_r    <= cmp_nxt;
    end
  end

  assign tok_o = tok_r;
  assign cmp_o = cmp_r;

endmodule

`default_nettype wire

// ===== test/tb_nearest_template_vowel_classifier.sv =====
// Self-checking testbench for the nearest template vowel classifier: fills the
// template table, runs directed and random frames over several energy floors.
// Depends on ntvc_pkg and the nearest_template_vowel_classifier top level.

module tb_nearest_template_vowel_classifier import ntvc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TEMPLATES = NUM_TEMPLATES_DEF;
  localparam int NUM_COEFFS    = NUM_COEFFS_DEF;
  localparam int RANGE_LIMIT   = 25600;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = NUM_TEMPLATES + 9;
  localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 64'd1;

  localparam bit MODE_LOAD    = 1'b0;
  localparam bit MODE_FEATURE = 1'b1;

  localparam logic [2:0] ADDR_ENERGY_FLOOR = 3'd0;

  typedef struct {
    bit                        mode;
    logic [2:0]                template_index;
    logic [3:0]                coeff_index;
    logic signed [COEFF_W-1:0] value;
    logic [31:0]               frame_energy;
    logic                      last;
  } vowel_request_t;

  typedef struct packed {
    logic [CODE_W-1:0] class_code;
    status_t           status;
  } vowel_result_t;

  class vowel_scoreboard;
    logic signed [COEFF_W-1:0] templates [NUM_TEMPLATES][NUM_COEFFS];
    longint unsigned           distance [NUM_TEMPLATES];
    bit                        range_error;
    logic [31:0]               energy_floor;
    vowel_result_t             expected_q [$];
    int                        mismatches;
    int                        requests;
    int                        results;
    int                        status_count [4];

    function void set_energy_floor(logic [31:0] floor_value);
      energy_floor = floor_value;
    endfunction

    // Updates the predicted state for one accepted request and queues the
    // classification that a frame-ending feature produces.
    function void note_request(vowel_request_t r);
      longint          diff;
      longint          mag;
      longint unsigned acc;
      vowel_result_t   res;
      int              best;
      requests++;
      if (r.mode == MODE_LOAD) begin
        if (r.template_index < NUM_TEMPLATES && r.coeff_index < NUM_COEFFS)
          templates[r.template_index][r.coeff_index] = r.value;
        return;
      end
      if (r.coeff_index < NUM_COEFFS) begin
        if (r.value >= RANGE_LIMIT || r.value <= -RANGE_LIMIT)
          range_error = 1'b1;
        for (int t = 0; t < NUM_TEMPLATES; t++) begin
          diff = longint'(templates[t][r.coeff_index]) - longint'(r.value);
          mag  = (diff < 0) ? -diff : diff;
          acc  = distance[t] + longint'(mag * mag);
          distance[t] = (acc > SUM_MAX) ? SUM_MAX : acc;
        end
      end
      if (!r.last)
        return;
      res.class_code = '0;
      if (!(r.frame_energy > energy_floor)) begin
        res.status = ST_QUIET;
      end else if (range_error) begin
        res.status = ST_RANGE;
      end else begin
        best = 0;
        for (int t = 1; t < NUM_TEMPLATES; t++)
          if (distance[t] < distance[best])
            best = t;
        res.class_code = CODE_W'(best + 1);
        res.status     = ST_OK;
      end
      expected_q.push_back(res);
      for (int t = 0; t < NUM_TEMPLATES; t++)
        distance[t] = 0;
      range_error = 1'b0;
    endfunction

    task report_mismatch(string what, logic [47:0] want, logic [47:0] got);
      mismatches++;
      $display("MISMATCH at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    task check_result(logic [CODE_W-1:0] code, logic [STAT_W-1:0] status);
      vowel_result_t want;
      results++;
      if (expected_q.size() == 0) begin
        report_mismatch("classification with no request pending", 0, code);
        return;
      end
      want = expected_q.pop_front();
      status_count[want.status]++;
      if (code !== want.class_code)
        report_mismatch("class_code", want.class_code, code);
      if (status !== want.status)
        report_mismatch("status", want.status, status);
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_mode = 1'b0;
  logic [2:0]                in_template_index = '0;
  logic [3:0]                in_coeff_index = '0;
  logic signed [COEFF_W-1:0] in_value = '0;
  logic [31:0]               in_frame_energy = '0;
  logic                      in_last = 1'b0;
  logic                      out_valid;
  logic [CODE_W-1:0]         out_class_code;
  logic [STAT_W-1:0]         out_status;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [2:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;

  vowel_scoreboard sb = new();
  bit              no_gaps = 1'b0;
  int              stall_cycles = 0;

  nearest_template_vowel_classifier i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_template_index (in_template_index),
    .in_coeff_index    (in_coeff_index),
    .in_value          (in_value),
    .in_frame_energy   (in_frame_energy),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_class_code    (out_class_code),
    .out_status        (out_status),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #1 clk = ~clk;

  // Results cannot be held off, so every strobe is checked in its own cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_class_code, out_status);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request, result or register write for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic vowel_request_t make_feature(int c, int v, logic [31:0] energy, bit last);
    vowel_request_t r;
    r.mode           = MODE_FEATURE;
    r.template_index = 3'($urandom_range(0, 7));
    r.coeff_index    = 4'(c);
    r.value          = 16'(v);
    r.frame_energy   = energy;
    r.last           = last;
    return r;
  endfunction

  function automatic vowel_request_t make_load(int t, int c, int v, bit last);
    vowel_request_t r;
    r.mode           = MODE_LOAD;
    r.template_index = 3'(t);
    r.coeff_index    = 4'(c);
    r.value          = 16'(v);
    r.frame_energy   = $urandom;
    r.last           = last;
    return r;
  endfunction

  // Start stays high across back-to-back requests; this task lowers it only
  // when a gap is drawn before the next request.
  task automatic send_request(input vowel_request_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_mode           <= r.mode;
    in_template_index <= r.template_index;
    in_coeff_index    <= r.coeff_index;
    in_value          <= r.value;
    in_frame_energy   <= r.frame_energy;
    in_last           <= r.last;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  // Waits until every classification has arrived and the pipeline is empty.
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ENERGY_FLOOR)
      sb.set_energy_floor(data);
  endtask

  // Mostly well-formed frames whose coefficients sit close to one template,
  // mixed with noisy frames, out-of-range values and stray table loads.
  task automatic run_random_frames(input int n_items);
    int          sent;
    int          len;
    int          t;
    int          c;
    int          v;
    int          choice;
    int          bad_pos;
    logic [31:0] energy;
    logic [31:0] floor_value;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0)
        no_gaps = !no_gaps;
      len     = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      t       = $urandom_range(0, NUM_TEMPLATES - 1);
      choice  = $urandom_range(0, 9);
      bad_pos = $urandom_range(0, len - 1);
      floor_value = sb.energy_floor;
      energy = $urandom;
      case ($urandom_range(0, 7))
        0: energy = floor_value;
        1: energy = 32'd0;
        2: ;
        default: begin
          if (energy <= floor_value && floor_value != '1)
            energy = floor_value + 32'd1 + (energy % (~floor_value));
        end
      endcase
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_request(make_load($urandom_range(0, 7), $urandom_range(0, NUM_COEFFS - 1),
                                 $urandom_range(0, 65535), $urandom_range(0, 1)));
          sent++;
        end
        c = (choice == 0) ? $urandom_range(0, NUM_COEFFS - 1) : k % NUM_COEFFS;
        if (choice == 0) begin
          v = $urandom_range(0, 65535);
        end else if (choice == 1 && k == bad_pos) begin
          v = $urandom_range(RANGE_LIMIT, 32768);
          if ($urandom_range(0, 1) == 1)
            v = -v;
        end else begin
          v = sb.templates[t][c] + int'($urandom_range(0, 1024)) - 512;
          if (v > RANGE_LIMIT - 1)
            v = RANGE_LIMIT - 1;
          if (v < 1 - RANGE_LIMIT)
            v = 1 - RANGE_LIMIT;
        end
        send_request(make_feature(c, v, (k == len - 1) ? energy : $urandom, k == len - 1));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_register(ADDR_ENERGY_FLOOR, 32'h0000_1000);

    // The whole table is written before any feature reads it.
    for (int t = 0; t < NUM_TEMPLATES; t++)
      for (int c = 0; c < NUM_COEFFS; c++)
        send_request(make_load(t, c, $urandom_range(0, 40000) - 20000, $urandom_range(0, 1)));

    // Exact match of one template at a single position.
    send_request(make_feature(0, sb.templates[3][0], 32'hFFFF_FFFF, 1'b1));
    // Largest positive and negative values, and the range limit on both sides.
    send_request(make_feature(1, 32767, $urandom, 1'b0));
    send_request(make_feature(2, 0, 32'hFFFF_FFFF, 1'b1));
    send_request(make_feature(3, -32768, 32'hFFFF_FFFF, 1'b1));
    send_request(make_feature(4, RANGE_LIMIT, 32'h0000_1001, 1'b1));
    send_request(make_feature(4, -RANGE_LIMIT, 32'h0000_1001, 1'b1));
    send_request(make_feature(5, RANGE_LIMIT - 1, 32'h0001_0000, 1'b1));
    send_request(make_feature(5, 1 - RANGE_LIMIT, 32'h0001_0000, 1'b1));
    // Energy equal to the floor and zero energy are both too quiet.
    send_request(make_feature(6, 100, 32'h0000_1000, 1'b1));
    send_request(make_feature(6, 100, 32'h0000_0000, 1'b1));
    // Too quiet wins over a range error in the same frame.
    send_request(make_feature(7, -32768, 32'h0000_0000, 1'b1));
    // All templates equal at one position: the first template wins the tie.
    for (int t = 0; t < NUM_TEMPLATES; t++)
      send_request(make_load(t, 15, 16'sh0100, 1'b0));
    send_request(make_feature(15, 16'sh0100, 32'h8000_0000, 1'b1));
    // A load in the middle of a frame, and a position repeated in the frame.
    send_request(make_feature(8, 1234, $urandom, 1'b0));
    send_request(make_load(2, 8, 32767, 1'b1));
    send_request(make_feature(8, -1234, 32'h0002_0000, 1'b1));
    // A load to a row beyond the table is dropped.
    send_request(make_load(7, 9, -32768, 1'b1));
    send_request(make_load(6, 14, -32768, 1'b1));
    send_request(make_load(5, 13, 32767, 1'b0));
    send_request(make_feature(13, 32767, 32'h0002_0000, 1'b1));
    drain();

    write_register(ADDR_ENERGY_FLOOR, 32'h0000_0000);
    run_random_frames(600);
    drain();
    write_register(ADDR_ENERGY_FLOOR, $urandom);
    run_random_frames(550);
    drain();
    write_register(ADDR_ENERGY_FLOOR, 32'hFFFF_FFFF);
    run_random_frames(100);
    drain();
    write_register(ADDR_ENERGY_FLOOR, 32'h8000_0000);
    run_random_frames(430);
    drain();

    $display("Run covered %0d requests and %0d classifications over five energy floors:",
             sb.requests, sb.results);
    $display("  %0d matched a template, %0d too quiet, %0d with a coefficient out of range.",
             sb.status_count[ST_OK], sb.status_count[ST_QUIET], sb.status_count[ST_RANGE]);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
